[hdl/tabulated_inverse_cdf_sampler_macros.svh]
// Assertion macros used by the sampler RTL.
`ifndef TABULATED_INVERSE_CDF_SAMPLER_MACROS_SVH
`define TABULATED_INVERSE_CDF_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define TICS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define TICS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tics_pkg.sv]
// Types and constants shared by the inverse-CDF sampler modules.
package tics_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned DEN_W     = 16;
  localparam int unsigned CUM_W     = 27;
  localparam int unsigned IT_W      = 7;
  localparam int unsigned RES_W     = 44;
  localparam int unsigned MAG_W     = 43;
  localparam int unsigned DVS_W     = 27;

  localparam logic [CNT_W-1:0] MAX_SAMPLES = 11'd1024;
  localparam logic [16:0]      ONE_Q       = 17'h10000;
  localparam logic [15:0]      X_START     = 16'd29491;
  localparam logic [15:0]      X_CLAMP     = 16'd58982;
  localparam logic [IT_W-1:0]  CAP_MAX     = 7'd64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  localparam logic METHOD_BISECT = 1'b0;

  localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [2:0] REG_METHOD       = 3'd1;
  localparam logic [2:0] REG_MAX_ITER     = 3'd2;
  localparam logic [2:0] REG_RES_LIMIT    = 3'd3;
  localparam logic [2:0] REG_STEP_LIMIT   = 3'd4;

  typedef enum logic [1:0] {
    STOP_RESIDUAL = 2'd0,
    STOP_STEP     = 2'd1,
    STOP_CAP      = 2'd2,
    STOP_ZERO     = 2'd3
  } stop_e;

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_LWR    = 17'h00002,
    ST_GTOT   = 17'h00004,
    ST_GPRE   = 17'h00008,
    ST_LOC    = 17'h00010,
    ST_RD0    = 17'h00020,
    ST_RD1    = 17'h00040,
    ST_MUL1   = 17'h00080,
    ST_SUM    = 17'h00100,
    ST_RES    = 17'h00200,
    ST_DECIDE = 17'h00400,
    ST_DIVMUL = 17'h00800,
    ST_DIVGO  = 17'h01000,
    ST_DIVWT  = 17'h02000,
    ST_UPD    = 17'h04000,
    ST_DONE   = 17'h08000,
    ST_SPARE  = 17'h10000
  } state_e;

endpackage

[hdl/tics_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module tics_div import tics_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [MAG_W-1:0] quotient_o
);

  logic [DVS_W-1:0] rem_q;
  logic [MAG_W-1:0] dq_q;
  logic [DVS_W-1:0] dv_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, dq_q[MAG_W-1]};
  assign ge      = shifted >= {1'b0, dv_q};
  assign diff    = shifted - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      dq_q  <= {dq_q[MAG_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

[hdl/tabulated_inverse_cdf_sampler.sv]
// Top level of the tabulated inverse-CDF sampler: tables, sequencer and ports.
// A load transaction reads the previous running sum on acceptance, then writes.
// A generate transaction reads the total in ST_GTOT and sets up in ST_GPRE, then runs
// bisection passes, plus one initial evaluation, or Newton passes using the divider.
// One transaction is worked on at a time; the result register frees the input side.
// Reset clears control state and restores register defaults; tables are not cleared.
module tabulated_inverse_cdf_sampler import tics_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: sample_index[9:0], sample_value[25:10], uniform[41:26], zero pad [47:42]
  input  logic [47:0] s_axis_tdata,
  // tuser: cmd
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: x_value[15:0], iterations[22:16], stop_reason[24:23], zero pad [31:25]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "tabulated_inverse_cdf_sampler_macros.svh"

  // Configuration registers.
  logic [CNT_W-1:0] sample_count_q;
  logic             method_q;
  logic [IT_W-1:0]  max_iter_q;
  logic [15:0]      res_limit_q;
  logic [15:0]      step_limit_q;
  logic [2:0]       reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= MAX_SAMPLES;
      method_q       <= METHOD_BISECT;
      max_iter_q     <= 7'd32;
      res_limit_q    <= 16'd1;
      step_limit_q   <= 16'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SAMPLE_COUNT: sample_count_q <= pwdata[CNT_W-1:0];
        REG_METHOD:       method_q       <= pwdata[0];
        REG_MAX_ITER:     max_iter_q     <= pwdata[IT_W-1:0];
        REG_RES_LIMIT:    res_limit_q    <= pwdata[15:0];
        REG_STEP_LIMIT:   step_limit_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SAMPLE_COUNT: prdata = {21'b0, sample_count_q};
      REG_METHOD:       prdata = {31'b0, method_q};
      REG_MAX_ITER:     prdata = {25'b0, max_iter_q};
      REG_RES_LIMIT:    prdata = {16'b0, res_limit_q};
      REG_STEP_LIMIT:   prdata = {16'b0, step_limit_q};
      default:          prdata = '0;
    endcase
  end

  // Effective sample count and iteration cap after clamping.
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] nm1;
  logic [IT_W-1:0]  cap;

  always_comb begin
    if (sample_count_q < 11'd2) begin
      n_eff = 11'd2;
    end else if (sample_count_q > MAX_SAMPLES) begin
      n_eff = MAX_SAMPLES;
    end else begin
      n_eff = sample_count_q;
    end
    nm1 = IDX_W'(n_eff - 11'd1);
    if (max_iter_q == 7'd0) begin
      cap = 7'd1;
    end else if (max_iter_q > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = max_iter_q;
    end
  end

  // Density and running-sum tables share one read address.
  logic [DEN_W-1:0] den_mem [1024];
  logic [CUM_W-1:0] cum_mem [1024];
  logic [DEN_W-1:0] den_rd_q;
  logic [CUM_W-1:0] cum_rd_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [CUM_W-1:0] cum_wdata;

  // Sequencer state and working registers.
  state_e            state_q;
  logic              in_acc;
  logic [IDX_W-1:0]  idx_q;
  logic [DEN_W-1:0]  val_q;
  logic [15:0]       u_q;
  logic [DEN_W-1:0]  prev_sample_q;
  logic [CUM_W-1:0]  total_q;
  logic [MAG_W-1:0]  ut_q;
  logic [MAG_W-1:0]  rlim_q;
  logic [15:0]       xe_q;
  logic [15:0]       x_q;
  logic [15:0]       prev_x_q;
  logic [16:0]       lo_q;
  logic [16:0]       hi_q;
  logic              lo_phase_q;
  logic signed [RES_W-1:0] rl_q;
  logic signed [RES_W-1:0] r_q;
  logic [IT_W-1:0]   it_q;
  logic [IDX_W-1:0]  seg_q;
  logic [16:0]       frac_q;
  logic [43:0]       pa_q;
  logic [43:0]       pb_q;
  logic [32:0]       da_q;
  logic [32:0]       db_q;
  logic [CUM_W-1:0]  c_q;
  logic [DEN_W-1:0]  d_q;
  logic [DVS_W-1:0]  divisor_q;
  logic [15:0]       res_x_q;
  logic [IT_W-1:0]   res_it_q;
  stop_e             res_reason_q;
  logic              m_valid_q;
  logic [31:0]       m_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      den_rd_q <= den_mem[rd_addr];
      cum_rd_q <= cum_mem[rd_addr];
    end
    if (wr_en) begin
      den_mem[idx_q] <= val_q;
      cum_mem[idx_q] <= cum_wdata;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = seg_q;
    case (state_q)
      ST_IDLE: begin
        rd_en   = in_acc;
        rd_addr = (s_axis_tuser == CMD_LOAD) ? s_axis_tdata[IDX_W-1:0] - 10'd1 : nm1;
      end
      ST_RD0: begin
        rd_en   = 1'b1;
        rd_addr = seg_q;
      end
      ST_RD1: begin
        rd_en   = 1'b1;
        rd_addr = seg_q + 10'd1;
      end
      default: ;
    endcase
  end

  assign wr_en     = (state_q == ST_LWR);
  assign cum_wdata = (idx_q == '0) ? '0
                   : CUM_W'(cum_rd_q + CUM_W'(prev_sample_q) + CUM_W'(val_q));

  // Segment and fraction of the evaluation point.
  logic [25:0]      p_w;
  logic [IDX_W-1:0] seg_w;
  logic [16:0]      frac_w;
  logic [16:0]      omf;

  assign p_w = 26'(xe_q) * 26'(nm1);
  always_comb begin
    if (p_w[25:16] >= nm1) begin
      seg_w  = nm1 - 10'd1;
      frac_w = ONE_Q;
    end else begin
      seg_w  = p_w[25:16];
      frac_w = {1'b0, p_w[15:0]};
    end
  end
  assign omf = ONE_Q - frac_q;

  // Decision logic on the finished residual.
  logic [MAG_W-1:0] r_mag;
  logic             opposite;
  logic [15:0]      step_diff;
  logic             step_hit;
  logic [16:0]      lo_n;
  logic [16:0]      hi_n;
  logic [17:0]      mid_sum;
  logic [IT_W-1:0]  it_inc;

  assign r_mag = r_q[RES_W-1] ? MAG_W'(-r_q) : MAG_W'(r_q);
  assign opposite = (rl_q[RES_W-1] && !r_q[RES_W-1] && (r_q != '0))
                 || (r_q[RES_W-1] && !rl_q[RES_W-1] && (rl_q != '0));
  assign step_diff = (xe_q > prev_x_q) ? xe_q - prev_x_q : prev_x_q - xe_q;
  assign step_hit  = (it_q != '0) && (step_diff < step_limit_q);
  assign lo_n      = opposite ? lo_q : {1'b0, xe_q};
  assign hi_n      = opposite ? {1'b0, xe_q} : hi_q;
  assign mid_sum   = 18'(lo_n) + 18'(hi_n);
  assign it_inc    = it_q + 7'd1;

  // Newton update from the divider quotient, truncated toward zero.
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [MAG_W-1:0] quo;
  logic [44:0]      x_up;
  logic [15:0]      x_new;

  assign div_start = (state_q == ST_DIVGO);
  assign x_up      = 45'(x_q) + 45'(quo);
  always_comb begin
    if (r_q[RES_W-1]) begin
      x_new = (x_up >= 45'(ONE_Q)) ? X_CLAMP : x_up[15:0];
    end else begin
      x_new = (quo > MAG_W'(x_q)) ? 16'd0 : x_q - quo[15:0];
    end
  end

  tics_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (r_mag),
    .divisor_i  (divisor_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Control registers of the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_valid_q     <= 1'b0;
      prev_sample_q <= '0;
      it_q          <= '0;
      lo_phase_q    <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= (s_axis_tuser == CMD_LOAD) ? ST_LWR : ST_GTOT;
          end
        end
        ST_LWR: begin
          prev_sample_q <= val_q;
          state_q       <= ST_IDLE;
        end
        ST_GTOT: state_q <= ST_GPRE;
        ST_GPRE: begin
          it_q       <= '0;
          lo_phase_q <= (method_q == METHOD_BISECT);
          state_q    <= (total_q == '0) ? ST_DONE : ST_LOC;
        end
        ST_LOC:  state_q <= ST_RD0;
        ST_RD0:  state_q <= ST_RD1;
        ST_RD1:  state_q <= ST_MUL1;
        ST_MUL1: state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_RES;
        ST_RES:  state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (method_q == METHOD_BISECT) begin
            if (lo_phase_q) begin
              lo_phase_q <= 1'b0;
              state_q    <= ST_LOC;
            end else if (r_mag < rlim_q || step_hit || it_inc == cap) begin
              state_q <= ST_DONE;
            end else begin
              it_q    <= it_inc;
              state_q <= ST_LOC;
            end
          end else if (r_mag < rlim_q || step_hit || d_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_DIVMUL;
          end
        end
        ST_DIVMUL: state_q <= ST_DIVGO;
        ST_DIVGO:  state_q <= ST_DIVWT;
        ST_DIVWT: begin
          if (div_done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          it_q    <= it_inc;
          state_q <= (it_inc == cap) ? ST_DONE : ST_LOC;
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_q <= s_axis_tdata[9:0];
          val_q <= s_axis_tdata[25:10];
          u_q   <= s_axis_tdata[41:26];
        end
      end
      ST_GTOT: total_q <= cum_rd_q;
      ST_GPRE: begin
        ut_q         <= MAG_W'(u_q) * MAG_W'(total_q);
        rlim_q       <= MAG_W'(res_limit_q) * MAG_W'(total_q);
        res_x_q      <= '0;
        res_it_q     <= '0;
        res_reason_q <= STOP_ZERO;
        prev_x_q     <= '0;
        lo_q         <= '0;
        hi_q         <= ONE_Q;
        x_q          <= (method_q == METHOD_BISECT) ? 16'd0 : X_START;
        xe_q         <= (method_q == METHOD_BISECT) ? 16'd0 : X_START;
      end
      ST_LOC: begin
        seg_q  <= seg_w;
        frac_q <= frac_w;
      end
      ST_RD1: begin
        pa_q <= 44'(cum_rd_q) * 44'(omf);
        da_q <= 33'(den_rd_q) * 33'(omf);
      end
      ST_MUL1: begin
        pb_q <= 44'(cum_rd_q) * 44'(frac_q);
        db_q <= 33'(den_rd_q) * 33'(frac_q);
      end
      ST_SUM: begin
        c_q <= CUM_W'((45'(pa_q) + 45'(pb_q)) >> FRAC_BITS);
        d_q <= DEN_W'((34'(da_q) + 34'(db_q)) >> FRAC_BITS);
      end
      ST_RES: r_q <= $signed(RES_W'({c_q, 16'b0})) - $signed(RES_W'(ut_q));
      ST_DECIDE: begin
        if (method_q == METHOD_BISECT) begin
          if (lo_phase_q) begin
            // The residual at the left end seeds the sign test; the first
            // midpoint comes from the untouched interval.
            rl_q <= r_q;
            xe_q <= 16'((18'(lo_q) + 18'(hi_q)) >> 1);
          end else begin
            lo_q     <= lo_n;
            hi_q     <= hi_n;
            prev_x_q <= xe_q;
            xe_q     <= 16'(mid_sum >> 1);
            if (!opposite) begin
              rl_q <= r_q;
            end
            res_x_q <= xe_q;
            if (r_mag < rlim_q) begin
              res_it_q     <= it_inc;
              res_reason_q <= STOP_RESIDUAL;
            end else if (step_hit) begin
              res_it_q     <= it_inc;
              res_reason_q <= STOP_STEP;
            end else begin
              res_it_q     <= cap;
              res_reason_q <= STOP_CAP;
            end
          end
        end else begin
          prev_x_q <= x_q;
          res_x_q  <= x_q;
          res_it_q <= it_inc;
          if (r_mag < rlim_q) begin
            res_reason_q <= STOP_RESIDUAL;
          end else if (step_hit) begin
            res_reason_q <= STOP_STEP;
          end else begin
            res_reason_q <= STOP_ZERO;
          end
        end
      end
      ST_DIVMUL: divisor_q <= DVS_W'({nm1, 1'b0}) * DVS_W'(d_q);
      ST_UPD: begin
        x_q          <= x_new;
        xe_q         <= x_new;
        res_x_q      <= x_new;
        res_it_q     <= cap;
        res_reason_q <= STOP_CAP;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {7'b0, res_reason_q, res_it_q, res_x_q};
        end
      end
      default: ;
    endcase
  end

  // A reported iteration count never exceeds the largest cap.
  `TICS_ASSERT_IMP(a_iter_bound, m_axis_tvalid, m_axis_tdata[22:16] <= CAP_MAX,
    "iteration count above cap")
  // Only the zero-density stop may report zero iterations.
  `TICS_ASSERT_IMP(a_iter_nonzero,
    m_axis_tvalid && (m_axis_tdata[24:23] != STOP_ZERO), m_axis_tdata[22:16] != 7'd0,
    "result with no iterations")
  // The divider is only started while it is free.
  `TICS_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider restarted while busy")
  // A started division keeps the sequencer waiting for it.
  `TICS_ASSERT_NXT(a_div_wait, div_start, state_q == ST_DIVWT && div_busy,
    "sequencer left the divider wait")

endmodule
